// File: src/ntpl_pkg.sv
// Shared types and constants of the nibble trie prefix lookup unit.
// Used by ntpl_store and nibble_trie_prefix_lookup_unit.
`default_nettype none

package ntpl_pkg;

  localparam int POOL_NODES = 4096;
  localparam int NODE_W     = $clog2(POOL_NODES);
  localparam int USED_W     = $clog2(POOL_NODES + 1);
  localparam int NIB_W      = 4;
  localparam int LINK_AW    = NODE_W + NIB_W;
  localparam int MAX_LEVELS = 8;
  localparam int LEVEL_W    = $clog2(MAX_LEVELS);
  localparam int LVCNT_W    = $clog2(MAX_LEVELS + 1);
  localparam int HOP_W      = 8;
  localparam int ADDR_W     = 32;
  localparam int PLEN_W     = 6;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_KEPT = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RLINK,
    S_RINFO,
    S_CHECK,
    S_HOP,
    S_DONE
  } state_t;

  // one child link position: parent node and the nibble taken from it
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [NIB_W-1:0]  nib;
  } slot_t;

  typedef struct packed {
    slot_t            parent;
    logic             hop_valid;
    logic [HOP_W-1:0] hop;
  } node_info_t;

  typedef struct packed {
    logic               link_rd;
    logic [LINK_AW-1:0] link_raddr;
    logic               link_we;
    logic [LINK_AW-1:0] link_waddr;
    logic [NODE_W-1:0]  link_wdata;
    logic               info_rd;
    logic [NODE_W-1:0]  info_raddr;
    logic               info_we;
    logic [NODE_W-1:0]  info_waddr;
    node_info_t         info_wdata;
  } mem_req_t;

endpackage

`default_nettype wire

// File: src/ntpl_store.sv
// Node pool storage: child link memory and per-node info memory.
// Synchronous, registered reads; depends on ntpl_pkg.
`default_nettype none

module ntpl_store
  import ntpl_pkg::*;
(
  input  wire logic              clk,
  input  wire mem_req_t          req,
  output      logic [NODE_W-1:0] link_rdata,
  output      node_info_t        info_rdata
);

  bit   [NODE_W-1:0] links [POOL_NODES * (2 ** NIB_W)];
  node_info_t        infos [POOL_NODES];

  always_ff @(posedge clk) begin
    if (req.link_we) begin
      links[req.link_waddr] <= req.link_wdata;
    end
    if (req.link_rd) begin
      link_rdata <= links[req.link_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.info_we) begin
      infos[req.info_waddr] <= req.info_wdata;
    end
    if (req.info_rd) begin
      info_rdata <= infos[req.info_raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/nibble_trie_prefix_lookup_unit.sv
// Stride-4 trie of IPv4 prefixes: route insert and longest prefix lookup.
// Top level; depends on ntpl_pkg and ntpl_store.
//
// One item is worked at a time. Each trie level is walked as a link read,
// a node info read and a check, following the dependent link-then-node
// read chain through the node pool; an insert that walks every level then
// writes its hop in a last step, unless one is already stored. No clearing
// pass follows reset: a child link counts only when the child index is
// allocated and the child's stored parent slot names the link's own slot,
// so stale memory contents are never trusted. The next item is taken while
// a result still waits on the output.
`default_nettype none

module nibble_trie_prefix_lookup_unit
  import ntpl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output      logic              in_stall,
  input  wire logic              kind,
  input  wire logic [ADDR_W-1:0] address,
  input  wire logic [PLEN_W-1:0] prefix_length,
  input  wire logic [HOP_W-1:0]  next_hop,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      logic              hit,
  output      logic [HOP_W-1:0]  hop_found,
  output      logic [1:0]        status
);

  state_t             state, state_next;
  kind_t              kind_q;
  logic [ADDR_W-1:0]  addr_sh;
  logic [LVCNT_W-1:0] levels_q;
  logic [LVCNT_W-1:0] levels_in;
  logic [HOP_W-1:0]   hop_q;
  logic [NODE_W-1:0]  node_q;
  logic [LEVEL_W-1:0] lv_q;
  logic [USED_W-1:0]  used;
  logic               hv_cur;
  slot_t              parent_q;
  logic               found_q;
  logic [HOP_W-1:0]   fhop_q;
  status_t            status_q;

  mem_req_t           req;
  logic [NODE_W-1:0]  link_rdata;
  node_info_t         info_rdata;

  slot_t              slot_cur;
  logic               child_ok;
  logic               at_last;
  logic               pool_full;
  logic               out_free;
  logic               alloc;

  ntpl_store u_store (
    .clk        (clk),
    .req        (req),
    .link_rdata (link_rdata),
    .info_rdata (info_rdata)
  );

  always_comb begin
    if (prefix_length > PLEN_W'(ADDR_W)) begin
      levels_in = LVCNT_W'(MAX_LEVELS);
    end else begin
      levels_in = LVCNT_W'(({1'b0, prefix_length} + (PLEN_W + 1)'(NIB_W - 1)) >> 2);
    end
  end

  assign slot_cur  = '{node: node_q, nib: addr_sh[ADDR_W-1 -: NIB_W]};
  assign child_ok  = (link_rdata != '0) && ({1'b0, link_rdata} < used)
                     && (info_rdata.parent == slot_cur);
  assign pool_full = (used == USED_W'(POOL_NODES));
  assign out_free  = !out_valid || !out_stall;
  assign at_last   = (kind_q == KIND_INSERT) ? ({1'b0, lv_q} == levels_q - 1'b1)
                                             : (lv_q == LEVEL_W'(MAX_LEVELS - 1));
  assign alloc     = (state == S_CHECK) && (kind_q == KIND_INSERT) && !child_ok
                     && !pool_full;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if ((kind == KIND_INSERT) && (levels_in == '0)) begin
            state_next = S_DONE;
          end else begin
            state_next = S_RLINK;
          end
        end
      end
      S_RLINK: state_next = S_RINFO;
      S_RINFO: state_next = S_CHECK;
      S_CHECK: begin
        if (kind_q == KIND_LOOKUP) begin
          state_next = (!child_ok || at_last) ? S_DONE : S_RLINK;
        end else if (!child_ok && pool_full) begin
          state_next = S_DONE;
        end else begin
          state_next = at_last ? S_HOP : S_RLINK;
        end
      end
      S_HOP: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall        = (state != S_IDLE);
    req.link_rd     = (state == S_RLINK);
    req.link_raddr  = slot_cur;
    req.link_we     = alloc;
    req.link_waddr  = slot_cur;
    req.link_wdata  = used[NODE_W-1:0];
    req.info_rd     = (state == S_RINFO);
    req.info_raddr  = link_rdata;
    req.info_we     = alloc || ((state == S_HOP) && !hv_cur);
    if (alloc) begin
      req.info_waddr = used[NODE_W-1:0];
      req.info_wdata = '{parent: slot_cur, hop_valid: 1'b0, hop: '0};
    end else begin
      req.info_waddr = node_q;
      req.info_wdata = '{parent: parent_q, hop_valid: 1'b1, hop: hop_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= USED_W'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (alloc) begin
        used <= used + 1'b1;
      end
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          kind_q   <= kind_t'(kind);
          addr_sh  <= address;
          levels_q <= levels_in;
          hop_q    <= next_hop;
          node_q   <= '0;
          lv_q     <= '0;
          found_q  <= 1'b0;
          fhop_q   <= '0;
          status_q <= ST_OK;
        end
      end
      S_CHECK: begin
        addr_sh <= addr_sh << NIB_W;
        lv_q    <= lv_q + 1'b1;
        if (kind_q == KIND_LOOKUP) begin
          if (child_ok) begin
            node_q <= link_rdata;
            if (info_rdata.hop_valid) begin
              found_q <= 1'b1;
              fhop_q  <= info_rdata.hop;
            end
          end
        end else if (child_ok) begin
          node_q   <= link_rdata;
          hv_cur   <= info_rdata.hop_valid;
          parent_q <= slot_cur;
        end else if (pool_full) begin
          status_q <= ST_FULL;
        end else begin
          node_q   <= used[NODE_W-1:0];
          hv_cur   <= 1'b0;
          parent_q <= slot_cur;
        end
      end
      S_HOP: begin
        if (hv_cur) begin
          status_q <= ST_KEPT;
        end
      end
      S_DONE: begin
        if (out_free) begin
          hit       <= found_q;
          hop_found <= fhop_q;
          status    <= status_q;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_used_range: assert property (@(posedge clk) disable iff (rst)
    (used >= USED_W'(1)) && (used <= USED_W'(POOL_NODES)))
    else $error("node count out of range");

  a_used_step: assert property (@(posedge clk) disable iff (rst)
    alloc |=> (used == $past(used) + 1'b1))
    else $error("node count did not advance on allocation");

  a_done_out: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && out_free) |=> (out_valid && (state == S_IDLE)))
    else $error("finished item not presented");

  a_hop_write: assert property (@(posedge clk) disable iff (rst)
    (req.info_we && !alloc) |-> ((state == S_HOP) && (kind_q == KIND_INSERT)))
    else $error("hop written outside insert");
`endif

endmodule

`default_nettype wire
